@@ sv/alarm_repeat_scheduler_defines.svh @@
// Assertion macros shared by the scheduler RTL.
`ifndef ALARM_REPEAT_SCHEDULER_DEFINES_SVH
`define ALARM_REPEAT_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ARS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ARS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/ars_pkg.sv @@
package ars_pkg;

    localparam int SLOTS_DEFAULT    = 16;
    localparam int SECONDS_PER_UNIT = 300;
    localparam int LIMIT_W          = 20;
    localparam int IN_DATA_W        = 104;
    localparam int OUT_DATA_W       = 72;
    localparam int CFG_DATA_W       = 11;

    typedef enum logic [2:0] {
        KIND_UPDATED   = 3'd0,
        KIND_INSERTED  = 3'd1,
        KIND_DROPPED   = 3'd2,
        KIND_SEND      = 3'd3,
        KIND_TICK_DONE = 3'd4
    } t_kind;

    typedef enum logic {
        FUNC_EVENT = 1'b0,
        FUNC_TICK  = 1'b1
    } t_func;

    typedef enum logic {
        CFG_REPEAT_COUNT   = 1'b0,
        CFG_INTERVAL_UNITS = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [15:0] proto_key;
        logic [15:0] param_key;
        logic [31:0] tag;
        logic [7:0]  remaining;
        logic        ever_sent;
        logic [31:0] last_time;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

@@ sv/alarm_repeat_scheduler.sv @@
// Alarm event: each slot is read (S_READ) and evaluated (S_EVAL) until a key match or the
// last slot, then S_EV_DONE stores the entry (unless dropped) and registers the result.
// Tick: each slot is read and evaluated in the same way, then S_TICK_DONE registers the
// closing word; a due entry or a result waits while the result register is held by a low
// m_axis_tready. A new item is taken only in S_IDLE, after the previous final word is registered.
// Reset clears the slot valid bits and sets both registers to one; the table RAM is kept.
`include "alarm_repeat_scheduler_defines.svh"

module alarm_repeat_scheduler
    import ars_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input words.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // proto_key[15:0], param_key[31:16], discard_alarm[32], alarm_tag[64:33],
    // now_seconds[96:65], zero[103:97]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func[0]
    input  logic                  s_axis_tuser,
    // Result words.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // slot[3:0], sent_proto[19:4], sent_param[35:20], sent_tag[67:36],
    // zero[71:68]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // kind[2:0]
    output logic [2:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_READ      = 5'b00010,
        S_EVAL      = 5'b00100,
        S_EV_DONE   = 5'b01000,
        S_TICK_DONE = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [SW-1:0]       r_idx, n_idx;
    logic [SLOTS-1:0]    r_valid, n_valid;
    logic                r_free_found, n_free_found;
    logic [SW-1:0]       r_free_idx, n_free_idx;
    logic [SW-1:0]       r_hit, n_hit;
    t_kind               r_kind, n_kind;
    t_func               r_func, n_func;
    logic [15:0]         r_proto, n_proto;
    logic [15:0]         r_param, n_param;
    logic [31:0]         r_tag, n_tag;
    logic [31:0]         r_now, n_now;
    logic [7:0]          r_count, n_count;
    logic [LIMIT_W-1:0]  r_limit, n_limit;
    logic [7:0]          r_repeat, n_repeat;
    logic [10:0]         r_interval, n_interval;
    logic                r_out_valid, n_out_valid;
    t_kind               r_out_kind, n_out_kind;
    logic [3:0]          r_out_slot, n_out_slot;
    logic [15:0]         r_out_proto, n_out_proto;
    logic [15:0]         r_out_param, n_out_param;
    logic [31:0]         r_out_tag, n_out_tag;
    logic                r_out_last, n_out_last;

    logic                w_ram_we;
    logic                w_ram_re;
    logic [SW-1:0]       w_ram_waddr;
    t_entry              w_ram_wdata;
    logic [ENTRY_W-1:0]  w_ram_rdata;
    t_entry              w_q;
    logic                w_out_free;
    logic                w_in_accept;
    logic [32:0]         w_diff;
    logic                w_due;
    logic [7:0]          w_new_rem;
    logic                w_last_slot;

    ars_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_idx),
        .o_rdata (w_ram_rdata)
    );

    assign w_q          = t_entry'(w_ram_rdata);
    assign o_cfg_ready  = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_accept  = s_axis_tvalid && s_axis_tready;
    assign w_out_free   = !r_out_valid || m_axis_tready;
    assign w_last_slot  = (r_idx == LAST_IDX);
    assign w_diff       = {1'b0, r_now} - {1'b0, w_q.last_time};
    assign w_due        = !w_q.ever_sent || (!w_diff[32] && (w_diff[31:0] > 32'(r_limit)));
    assign w_new_rem    = (w_q.remaining != 8'd0) ? (w_q.remaining - 8'd1) : 8'd0;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_valid      = r_valid;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_hit        = r_hit;
        n_kind       = r_kind;
        n_func       = r_func;
        n_proto      = r_proto;
        n_param      = r_param;
        n_tag        = r_tag;
        n_now        = r_now;
        n_count      = r_count;
        n_limit      = r_limit;
        n_repeat     = r_repeat;
        n_interval   = r_interval;
        n_out_valid  = r_out_valid;
        n_out_kind   = r_out_kind;
        n_out_slot   = r_out_slot;
        n_out_proto  = r_out_proto;
        n_out_param  = r_out_param;
        n_out_tag    = r_out_tag;
        n_out_last   = r_out_last;
        w_ram_we     = 1'b0;
        w_ram_re     = 1'b0;
        w_ram_waddr  = r_idx;
        w_ram_wdata  = w_q;

        if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_REPEAT_COUNT:   n_repeat   = i_cfg_data[7:0];
                CFG_INTERVAL_UNITS: n_interval = i_cfg_data[10:0];
                default: ;
            endcase
        end

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_func       = t_func'(s_axis_tuser);
                    n_proto      = s_axis_tdata[15:0];
                    n_param      = s_axis_tdata[31:16];
                    n_tag        = s_axis_tdata[64:33];
                    n_now        = s_axis_tdata[96:65];
                    n_count      = (s_axis_tdata[32] || (r_repeat == 8'd0)) ? 8'd1 : r_repeat;
                    n_limit      = LIMIT_W'(r_interval) * LIMIT_W'(SECONDS_PER_UNIT);
                    n_idx        = '0;
                    n_free_found = 1'b0;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                w_ram_re = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                if (r_func == FUNC_EVENT) begin
                    if (r_valid[r_idx] && (w_q.proto_key == r_proto) &&
                        (w_q.param_key == r_param)) begin
                        n_hit   = r_idx;
                        n_kind  = KIND_UPDATED;
                        n_state = S_EV_DONE;
                    end else begin
                        if (!r_valid[r_idx] && !r_free_found) begin
                            n_free_found = 1'b1;
                            n_free_idx   = r_idx;
                        end
                        if (w_last_slot) begin
                            if (r_free_found || !r_valid[r_idx]) begin
                                n_hit  = r_free_found ? r_free_idx : r_idx;
                                n_kind = KIND_INSERTED;
                            end else begin
                                n_hit  = '0;
                                n_kind = KIND_DROPPED;
                            end
                            n_state = S_EV_DONE;
                        end else begin
                            n_idx   = r_idx + SW'(1);
                            n_state = S_READ;
                        end
                    end
                end else begin
                    if (!r_valid[r_idx] || !w_due || w_out_free) begin
                        if (r_valid[r_idx] && w_due) begin
                            w_ram_we              = 1'b1;
                            w_ram_wdata.remaining = w_new_rem;
                            w_ram_wdata.ever_sent = 1'b1;
                            w_ram_wdata.last_time = r_now;
                            n_out_valid = 1'b1;
                            n_out_kind  = KIND_SEND;
                            n_out_slot  = 4'(r_idx);
                            n_out_proto = w_q.proto_key;
                            n_out_param = w_q.param_key;
                            n_out_tag   = w_q.tag;
                            n_out_last  = 1'b0;
                            if (w_new_rem == 8'd0) begin
                                n_valid[r_idx] = 1'b0;
                            end
                        end else if (r_valid[r_idx] && (w_q.remaining == 8'd0)) begin
                            n_valid[r_idx] = 1'b0;
                        end
                        if (w_last_slot) begin
                            n_state = S_TICK_DONE;
                        end else begin
                            n_idx   = r_idx + SW'(1);
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_EV_DONE: begin
                if (w_out_free) begin
                    if (r_kind != KIND_DROPPED) begin
                        w_ram_we    = 1'b1;
                        w_ram_waddr = r_hit;
                        w_ram_wdata = '{proto_key: r_proto, param_key: r_param,
                                        tag: r_tag, remaining: r_count,
                                        ever_sent: 1'b0, last_time: 32'd0};
                        n_valid[r_hit] = 1'b1;
                    end
                    n_out_valid = 1'b1;
                    n_out_kind  = r_kind;
                    n_out_slot  = 4'(r_hit);
                    n_out_proto = '0;
                    n_out_param = '0;
                    n_out_tag   = '0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_TICK_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_TICK_DONE;
                    n_out_slot  = '0;
                    n_out_proto = '0;
                    n_out_param = '0;
                    n_out_tag   = '0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_valid      <= '0;
            r_free_found <= 1'b0;
            r_repeat     <= 8'd1;
            r_interval   <= 11'd1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_valid      <= n_valid;
            r_free_found <= n_free_found;
            r_repeat     <= n_repeat;
            r_interval   <= n_interval;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_free_idx  <= n_free_idx;
        r_hit       <= n_hit;
        r_kind      <= n_kind;
        r_func      <= n_func;
        r_proto     <= n_proto;
        r_param     <= n_param;
        r_tag       <= n_tag;
        r_now       <= n_now;
        r_count     <= n_count;
        r_limit     <= n_limit;
        r_out_kind  <= n_out_kind;
        r_out_slot  <= n_out_slot;
        r_out_proto <= n_out_proto;
        r_out_param <= n_out_param;
        r_out_tag   <= n_out_tag;
        r_out_last  <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {4'd0, r_out_tag, r_out_param, r_out_proto, r_out_slot};

    `ARS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "input accepted while an item was still in progress")
    `ARS_ASSERT_NOW(a_send_not_last, m_axis_tvalid && (m_axis_tuser == KIND_SEND),
        !m_axis_tlast, "send word marked as final word")
    `ARS_ASSERT_NEXT(a_write_sets_valid,
        (r_state == S_EV_DONE) && w_out_free && (r_kind != KIND_DROPPED),
        r_valid[r_hit], "stored alarm entry not marked valid")
    `ARS_ASSERT_NOW(a_done_holds_output, (r_state == S_EV_DONE) && !w_out_free,
        m_axis_tvalid && !m_axis_tready, "event result stalled without a pending word")

endmodule

@@ sv/ars_ram.sv @@
module ars_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
